FILE: rtl/core/sia_pkg.sv
package sia_pkg;

	// Input width and derived sizes
	localparam int VALUE_BITS    = 32;
	// Digit count of 2^(VALUE_BITS-1): floor((VALUE_BITS-1)*log10(2)) + 1
	localparam int DIGITS        = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int BCD_BITS      = DIGITS * 4;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_BITS      = STEPS * BITS_PER_STEP;
	localparam int STEP_CNT_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int REMAIN_W      = $clog2(DIGITS + 1);
	localparam int CHAR_BITS     = 7;

	// Character codes
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 7'd57;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} sia_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic step;
		logic advance;
		logic out_sign;
		logic out_digit;
	} sia_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic neg;
		logic top_zero;
		logic remain_one;
	} sia_sts_t;

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
// Input channel: value (signed, VALUE_BITS wide) with in_valid / in_stall.
// A transaction is taken when in_valid is high and in_stall is low.
// Output channel: char_code / last_char with out_valid / out_stall, one
// character per transaction, most significant first, '-' ahead of a
// negative number, last_char set on the final digit.
// Conversion is double dabble at four bits per cycle. Leading zeros are then
// dropped at one digit per cycle, and characters leave at one per cycle from a
// single output register while out_stall is low. One number is in work at a
// time; the next is accepted as soon as the last character is in the output
// register, even while that character is still stalled.
// While out_stall is high a valid output character holds and the next character waits.
// Reset clears the controller and drops any pending character; no memory
// needs clearing.
module signed_int_to_decimal_ascii (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [sia_pkg::VALUE_BITS-1:0] value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [sia_pkg::CHAR_BITS-1:0]         char_code,
	output logic                                  last_char
);
	import sia_pkg::*;

	sia_cmd_t cmd;
	sia_sts_t sts;

	sia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	sia_datapath u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule

FILE: rtl/core/sia_datapath.sv
module sia_datapath (
	input  logic                                  clk,
	input  sia_pkg::sia_cmd_t                     cmd,
	output sia_pkg::sia_sts_t                     sts,
	input  logic signed [sia_pkg::VALUE_BITS-1:0] value,
	output logic [sia_pkg::CHAR_BITS-1:0]         char_code,
	output logic                                  last_char
);
	import sia_pkg::*;

	logic [BCD_BITS-1:0]  bcd_q;
	logic [PAD_BITS-1:0]  bin_q;
	logic [REMAIN_W-1:0]  remain_q;
	logic                 neg_q;
	logic [CHAR_BITS-1:0] char_code_q;
	logic                 last_char_q;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic [BCD_BITS-1:0]   bcd_next;
	logic [PAD_BITS-1:0]   bin_next;
	logic [3:0]            top_digit;

	// Magnitude as unsigned; the most negative value maps to 2^(N-1) exactly
	assign raw = value;
	assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

	// Double dabble, four binary bits per cycle
	always_comb begin
		logic [BCD_BITS-1:0] bcd_v;
		logic [PAD_BITS-1:0] bin_v;
		bcd_v = bcd_q;
		bin_v = bin_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_v[d*4 +: 4] >= 4'd5) begin
					bcd_v[d*4 +: 4] = bcd_v[d*4 +: 4] + 4'd3;
				end
			end
			{bcd_v, bin_v} = {bcd_v[BCD_BITS-2:0], bin_v, 1'b0};
		end
		bcd_next = bcd_v;
		bin_next = bin_v;
	end

	assign top_digit = bcd_q[BCD_BITS-1 -: 4];

	// Conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bcd_q    <= '0;
			bin_q    <= PAD_BITS'(mag);
			neg_q    <= raw[VALUE_BITS-1];
			remain_q <= REMAIN_W'(DIGITS);
		end else if (cmd.step) begin
			bcd_q <= bcd_next;
			bin_q <= bin_next;
		end else if (cmd.advance) begin
			bcd_q    <= {bcd_q[BCD_BITS-5:0], 4'd0};
			remain_q <= remain_q - 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_sign) begin
			char_code_q <= CHAR_MINUS;
			last_char_q <= 1'b0;
		end else if (cmd.out_digit) begin
			char_code_q <= CHAR_ZERO + {3'd0, top_digit};
			last_char_q <= sts.remain_one;
		end
	end

	assign sts.neg        = neg_q;
	assign sts.top_zero   = (top_digit == 4'd0);
	assign sts.remain_one = (remain_q == REMAIN_W'(1));

	assign char_code = char_code_q;
	assign last_char = last_char_q;

endmodule

FILE: rtl/core/sia_ctrl.sv
module sia_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output sia_pkg::sia_cmd_t cmd,
	input  sia_pkg::sia_sts_t sts
);
	import sia_pkg::*;

	sia_state_t            state_q;
	sia_state_t            state_next;
	logic [STEP_CNT_W-1:0] step_q;
	logic                  out_valid_q;
	logic                  out_free;

	// Output register can take a new character
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.out_sign || cmd.out_digit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_next    = state_q;
		cmd           = '0;
		in_stall      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (step_q == STEP_CNT_W'(STEPS - 1)) begin
					state_next = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zero digits, keep at least one
				if (sts.top_zero && !sts.remain_one) begin
					cmd.advance = 1'b1;
				end else begin
					state_next = sts.neg ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					cmd.out_sign = 1'b1;
					state_next   = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (out_free) begin
					cmd.out_digit = 1'b1;
					cmd.advance   = 1'b1;
					if (sts.remain_one) begin
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/sia_checker.sv
module sia_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sia_pkg::CHAR_BITS-1:0] char_code,
	input logic                          last_char
);
	import sia_pkg::*;

	// Stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last_char))
		else $error("output changed while stalled");

	// One number at a time: busy right after an input transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while converting");

	// Only minus sign or digits are emitted
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == CHAR_MINUS) ||
			((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE)))
		else $error("illegal character code");

	// A sign never ends the text
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_code == CHAR_MINUS) |-> !last_char)
		else $error("minus sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii sia_checker u_sia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.char_code (char_code),
	.last_char (last_char)
);

FILE: bench/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test;
	import sia_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 150;
	localparam int HOLD_AFTER     = 60;
	localparam int CALM_TAIL      = 40;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_NUMBERS = 300;
	localparam int DRAIN_CYCLES   = 40;

	// Corner values: zero, single digits, powers of ten, extremes, bit patterns
	localparam logic [VALUE_BITS-1:0] CORNER_VALUES [0:18] = '{
		0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345,
		999999999, 1000000000, -1000000000,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
		32'h5555_5555, 32'hAAAA_AAAA
	};

	typedef struct packed {
		logic [CHAR_BITS-1:0] code;
		logic                 last;
	} ascii_char_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic signed [VALUE_BITS-1:0] value;
	logic                         out_valid;
	logic                         out_stall;
	logic [CHAR_BITS-1:0]         char_code;
	logic                         last_char;

	logic [VALUE_BITS-1:0] pending_values[$];
	ascii_char_t           expected_chars[$];
	logic                  running = 1'b0;
	logic                  in_taken = 1'b0;
	int                    numbers_taken = 0;
	int                    quiet_cycles = 0;
	int                    errors = 0;

	signed_int_to_decimal_ascii DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Decimal text of one number: sign first, then digits, last flag on the final digit
	function automatic void append_decimal_text(input logic [VALUE_BITS-1:0] num);
		logic [VALUE_BITS-1:0] mag;
		logic [CHAR_BITS-1:0]  digits[$];
		logic                  neg;
		ascii_char_t           ch;
		neg = num[VALUE_BITS-1];
		mag = neg ? (~num + 1'b1) : num;
		do begin
			digits.push_front(CHAR_ZERO + CHAR_BITS'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (neg) begin
			ch.code = CHAR_MINUS;
			ch.last = 1'b0;
			expected_chars.push_back(ch);
		end
		foreach (digits[i]) begin
			ch.code = digits[i];
			ch.last = (i == digits.size() - 1);
			expected_chars.push_back(ch);
		end
	endfunction

	// Sender: new number or idle burst after each transaction; stalled payload holds
	int send_gap = 0;
	always @(negedge clk) begin
		if (running && !(in_valid && !in_taken)) begin
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_values.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_values.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 5);
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				value <= pending_values.pop_front();
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off to back up the block
	int stall_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	always @(negedge clk) begin
		if (running) begin
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (!hold_done && numbers_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				out_stall <= 1'b1;
			end else if (pending_values.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: input transactions feed the prediction, output transactions are checked
	always @(posedge clk) begin
		if (running) begin
			in_taken <= in_valid && !in_stall;
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (in_valid && !in_stall) begin
				append_decimal_text(value);
				numbers_taken <= numbers_taken + 1;
			end
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					errors <= errors + 1;
					if (errors < MAX_REPORTS)
						$display("unexpected char: code %0d last %0b", char_code, last_char);
				end else begin
					if (char_code !== expected_chars[0].code
							|| last_char !== expected_chars[0].last) begin
						errors <= errors + 1;
						if (errors < MAX_REPORTS)
							$display("char mismatch: expected code %0d last %0b, got code %0d last %0b",
								expected_chars[0].code, expected_chars[0].last,
								char_code, last_char);
					end
					void'(expected_chars.pop_front());
				end
			end
		end
	end

	// Watchdog on stretches with no transaction on either side
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		logic [VALUE_BITS-1:0] num;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		out_stall = 1'b0;

		foreach (CORNER_VALUES[i])
			pending_values.push_back(CORNER_VALUES[i]);
		for (int n = 0; n < RANDOM_NUMBERS; n++) begin
			case ($urandom_range(0, 3))
				0: num = $urandom;
				1: num = $urandom_range(0, 99);
				2: num = $urandom_range(0, 999999);
				default: num = $urandom_range(0, 99999999);
			endcase
			if ($urandom_range(0, 1))
				num = -num;
			pending_values.push_back(num);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		running = 1'b1;

		while (pending_values.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
